FILE: hdl/irigb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IRIG-B decoder package
// Shared types, codes and the month length table.
// ----------------------------------------------------------------------------
package irigb_pkg;

   localparam int TICK_W = 18;
   localparam int TOL_W  = 16;

   localparam logic [1:0] CSR_SHORT = 2'd0;
   localparam logic [1:0] CSR_MID   = 2'd1;
   localparam logic [1:0] CSR_LONG  = 2'd2;
   localparam logic [1:0] CSR_TOL   = 2'd3;

   localparam logic OP_EDGE    = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   localparam logic [7:0] POS_UNALIGNED = 8'hFF;
   localparam logic [3:0] QUAL_BAD      = 4'd15;

   typedef enum logic [1:0] {
      SYM_ERR  = 2'd0,
      SYM_P    = 2'd1,
      SYM_ONE  = 2'd2,
      SYM_ZERO = 2'd3
   } sym_type;

   typedef enum logic [1:0] {
      LEAP_NONE    = 2'd0,
      LEAP_PENDING = 2'd1,
      LEAP_POS     = 2'd2,
      LEAP_NEG     = 2'd3
   } leap_type;

   typedef enum logic [1:0] {
      BK_RUN   = 2'd0,
      BK_MONTH = 2'd1,
      BK_DONE  = 2'd2
   } back_state_type;

   typedef struct packed {
      logic                op;
      logic                line_level;
      logic [TICK_W-1:0]   interval_ticks;
   } req_type;

   typedef struct packed {
      logic       in_frame;
      logic       frame_done;
      logic [6:0] out_year;
      logic [3:0] out_month;
      logic [8:0] out_day;
      logic [4:0] out_hour;
      logic [5:0] out_minute;
      logic [5:0] out_second;
      logic [9:0] out_millisecond;
      logic [3:0] out_quality;
      logic [1:0] leap_flag;
   } rsp_type;

   // one classified event: decode tells whether the symbol is fed to the framer
   typedef struct packed {
      logic    decode;
      sym_type sym;
   } sym_word_type;

   typedef struct packed {
      logic         empty;
      sym_word_type word;
   } sym_link_type;

   function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
      logic [4:0] len;
      unique case (idx)
         4'd1:                      len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/irigb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IRIG-B front end
// Holds the width registers, classifies edges and timeouts into symbols and
// queues them for the framer.
// ----------------------------------------------------------------------------
module irigb_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   output logic                           full,
   input  wire irigb_pkg::req_type        req_word,
   input  wire logic                      csr_wr_en,
   input  wire logic [1:0]                csr_index,
   input  wire logic [17:0]               csr_wdata,
   output irigb_pkg::sym_link_type        sym_link,
   input  wire logic                      sym_pop
);
   import irigb_pkg::*;

   logic [TICK_W-1:0] short_ff, mid_ff, long_ff;
   logic [TOL_W-1:0]  tol_ff;
   sym_type           class_ff, class_in;
   sym_word_type      q_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;
   sym_word_type      word_in;
   logic              accept;
   logic              near_s, near_m, near_l, near_sel;

   function automatic logic near_width(input logic [TICK_W-1:0] t,
                                       input logic [TICK_W-1:0] n,
                                       input logic [TOL_W-1:0]  tol);
      logic [TICK_W:0] a, b;
      a = {1'b0, t} + {{(TICK_W+1-TOL_W){1'b0}}, tol};
      b = {1'b0, n} + {{(TICK_W+1-TOL_W){1'b0}}, tol};
      return (a > {1'b0, n}) && ({1'b0, t} < b);
   endfunction

   assign full   = (count_ff == 2'd2);
   assign accept = push && !full;

   assign near_s = near_width(req_word.interval_ticks, short_ff, tol_ff);
   assign near_m = near_width(req_word.interval_ticks, mid_ff, tol_ff);
   assign near_l = near_width(req_word.interval_ticks, long_ff, tol_ff);

   always_comb begin
      class_in     = class_ff;
      word_in      = '{decode: 1'b0, sym: SYM_ERR};
      near_sel     = 1'b0;
      unique case (class_ff)
         SYM_P:    near_sel = near_s;
         SYM_ONE:  near_sel = near_m;
         SYM_ZERO: near_sel = near_l;
         default:  near_sel = 1'b0;
      endcase
      if (req_word.op == OP_TIMEOUT) begin
         class_in = SYM_ERR;
         word_in  = '{decode: 1'b1, sym: SYM_ERR};
      end else if (req_word.line_level) begin
         // rising edge closes the low part of the bit
         if (class_ff != SYM_ERR) begin
            word_in = '{decode: 1'b1, sym: near_sel ? class_ff : SYM_ERR};
         end
      end else begin
         priority if (near_l) begin
            class_in = SYM_P;
         end else if (near_m) begin
            class_in = SYM_ONE;
         end else if (near_s) begin
            class_in = SYM_ZERO;
         end else begin
            class_in = SYM_ERR;
            word_in  = '{decode: 1'b1, sym: SYM_ERR};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff  <= TICK_W'(36000);
         mid_ff    <= TICK_W'(90000);
         long_ff   <= TICK_W'(144000);
         tol_ff    <= TOL_W'(3600);
         class_ff  <= SYM_ERR;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SHORT: short_ff <= csr_wdata;
               CSR_MID:   mid_ff   <= csr_wdata;
               CSR_LONG:  long_ff  <= csr_wdata;
               CSR_TOL:   tol_ff   <= csr_wdata[TOL_W-1:0];
               default:   ;
            endcase
         end
         if (accept) begin
            class_ff  <= class_in;
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (sym_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, accept} - {1'b0, sym_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) q_ff[wr_ptr_ff] <= word_in;
   end

   assign sym_link.empty = (count_ff == 2'd0);
   assign sym_link.word  = q_ff[rd_ptr_ff];

endmodule
`default_nettype wire

FILE: hdl/irigb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IRIG-B framer and publisher
// Tracks frame position, gathers the BCD fields, publishes the time plus one
// second with a month walk, and queues one result word per event.
// ----------------------------------------------------------------------------
module irigb_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire irigb_pkg::sym_link_type  sym_link,
   output logic                          sym_pop,
   output logic                          empty,
   input  wire logic                     pop,
   output irigb_pkg::rsp_type            rsp_word
);
   import irigb_pkg::*;

   back_state_type state_ff, state_in;
   logic [7:0]  pos_ff, pos_in;
   leap_type    leap_ff, leap_in;
   logic [7:0]  sec_sh_ff, sec_sh_in, min_sh_ff, min_sh_in, hour_sh_ff, hour_sh_in;
   logic [7:0]  year_sh_ff, year_sh_in, qual_sh_ff, qual_sh_in;
   logic [15:0] day_sh_ff, day_sh_in;
   logic [6:0]  p_year_ff, p_year_in;
   logic [3:0]  p_mon_ff, p_mon_in;
   logic [8:0]  p_day_ff, p_day_in;
   logic [4:0]  p_hour_ff, p_hour_in;
   logic [5:0]  p_min_ff, p_min_in, p_sec_ff, p_sec_in;
   logic [9:0]  p_ms_ff, p_ms_in;
   logic [3:0]  p_qual_ff, p_qual_in;
   logic [3:0]  m_idx_ff, m_idx_in;
   logic [8:0]  m_sum_ff, m_sum_in;

   rsp_type     q_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        out_full, out_push;
   rsp_type     out_word;

   assign out_full = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rsp_word = q_ff[rd_ptr_ff];

   always_comb begin
      logic       bad, data, b, publish, is_marker, is_zero_pos, lp;
      logic [7:0] p, t8, s, m, h, y, limit;
      logic [15:0] t16, d;
      logic [4:0] len;
      logic [9:0] ms_sum;
      sym_type    sym;

      state_in   = state_ff;
      pos_in     = pos_ff;
      leap_in    = leap_ff;
      sec_sh_in  = sec_sh_ff;
      min_sh_in  = min_sh_ff;
      hour_sh_in = hour_sh_ff;
      day_sh_in  = day_sh_ff;
      year_sh_in = year_sh_ff;
      qual_sh_in = qual_sh_ff;
      p_year_in  = p_year_ff;
      p_mon_in   = p_mon_ff;
      p_day_in   = p_day_ff;
      p_hour_in  = p_hour_ff;
      p_min_in   = p_min_ff;
      p_sec_in   = p_sec_ff;
      p_ms_in    = p_ms_ff;
      p_qual_in  = p_qual_ff;
      m_idx_in   = m_idx_ff;
      m_sum_in   = m_sum_ff;
      sym_pop    = 1'b0;
      out_push   = 1'b0;
      out_word   = '0;
      bad = 1'b0; publish = 1'b0; t8 = '0; t16 = '0;
      s = '0; m = '0; h = '0; y = '0; d = '0; limit = 8'd59;
      len = '0; ms_sum = '0; lp = 1'b0;
      sym  = sym_link.word.sym;
      p    = pos_ff;
      data = (sym == SYM_ONE) || (sym == SYM_ZERO);
      b    = (sym == SYM_ONE);
      is_marker = (p == 8'd0) || (p == 8'd9) || (p == 8'd19) || (p == 8'd29) ||
                  (p == 8'd39) || (p == 8'd49) || (p == 8'd59) || (p == 8'd69) ||
                  (p == 8'd79) || (p == 8'd89) || (p == 8'd99);
      is_zero_pos = (p == 8'd5) || (p == 8'd14) || (p == 8'd18) || (p == 8'd24) ||
                    (p == 8'd27) || (p == 8'd28) || (p == 8'd34) ||
                    ((p >= 8'd42) && (p <= 8'd48)) || (p == 8'd54) || (p == 8'd98);

      unique case (state_ff)
         BK_RUN: begin
            if (!sym_link.empty && !out_full) begin
               sym_pop = 1'b1;
               if (sym_link.word.decode) begin
                  if (p == POS_UNALIGNED) begin
                     if (sym == SYM_P) pos_in = 8'd0;
                     else p_qual_in = QUAL_BAD;
                  end else begin
                     priority if (is_marker) begin
                        bad = (sym != SYM_P);
                     end else if (is_zero_pos) begin
                        bad = (sym != SYM_ZERO);
                     end else if (p <= 8'd8) begin
                        if (!data) bad = 1'b1;
                        else begin
                           t8 = {b, sec_sh_ff[7:1]};
                           if (p == 8'd8) begin
                              t8 = t8 >> 1;
                              t8 = 8'({4'd0, t8[7:4] & 4'h7} * 8'd10) + {4'd0, t8[3:0]};
                              if (t8 > 8'd60) bad = 1'b1;
                           end
                           sec_sh_in = t8;
                        end
                     end else if (p >= 8'd10 && p <= 8'd17) begin
                        if (!data) bad = 1'b1;
                        else begin
                           t8 = {b, min_sh_ff[7:1]};
                           if (p == 8'd17) begin
                              t8 = t8 >> 1;
                              t8 = 8'({4'd0, t8[7:4] & 4'h7} * 8'd10) + {4'd0, t8[3:0]};
                              if (t8 > 8'd59) bad = 1'b1;
                           end
                           min_sh_in = t8;
                        end
                     end else if (p >= 8'd20 && p <= 8'd26) begin
                        if (!data) bad = 1'b1;
                        else begin
                           t8 = {b, hour_sh_ff[7:1]};
                           if (p == 8'd26) begin
                              t8 = t8 >> 2;
                              t8 = 8'({4'd0, t8[7:4] & 4'h3} * 8'd10) + {4'd0, t8[3:0]};
                              if (t8 > 8'd23) bad = 1'b1;
                           end
                           hour_sh_in = t8;
                        end
                     end else if (p >= 8'd30 && p <= 8'd41) begin
                        if (!data) bad = 1'b1;
                        else begin
                           t16 = {b, day_sh_ff[15:1]};
                           if (p == 8'd41) begin
                              t16 = t16 >> 6;
                              t16 = 16'({14'd0, t16[9:8]} * 16'd100) +
                                    16'({12'd0, t16[7:4]} * 16'd10) + {12'd0, t16[3:0]};
                              if (t16 > 16'd366) bad = 1'b1;
                           end
                           day_sh_in = t16;
                        end
                     end else if (p >= 8'd50 && p <= 8'd58) begin
                        if (!data) bad = 1'b1;
                        else begin
                           t8 = {b, year_sh_ff[7:1]};
                           if (p == 8'd58) begin
                              t8 = 8'({4'd0, t8[7:4]} * 8'd10) + {4'd0, t8[3:0]};
                              if (t8 > 8'd99) bad = 1'b1;
                           end
                           year_sh_in = t8;
                        end
                     end else if (p == 8'd60) begin
                        if (!data) bad = 1'b1;
                        else if (sec_sh_ff == 8'd57) leap_in = b ? LEAP_PENDING : LEAP_NONE;
                     end else if (p == 8'd61) begin
                        if (!data) bad = 1'b1;
                        else if (sec_sh_ff == 8'd57 && leap_ff == LEAP_PENDING)
                           leap_in = b ? LEAP_POS : LEAP_NEG;
                     end else if (p >= 8'd71 && p <= 8'd74) begin
                        if (!data) bad = 1'b1;
                        else begin
                           t8 = {b, qual_sh_ff[7:1]};
                           if (p == 8'd74) t8 = (t8 >> 4) & 8'h0F;
                           qual_sh_in = t8;
                        end
                     end else begin
                        bad = (sym == SYM_ERR);
                     end

                     if (bad) begin
                        pos_in    = POS_UNALIGNED;
                        p_qual_in = QUAL_BAD;
                     end else if (p == 8'd99) begin
                        publish = 1'b1;
                        pos_in  = 8'd0;
                     end else begin
                        pos_in  = p + 8'd1;
                        ms_sum  = p_ms_ff + 10'd10;
                        p_ms_in = (p_ms_ff > 10'd1013) ? 10'd1023 : ms_sum;
                     end
                  end
               end

               if (publish) begin
                  // add one second with leap-aware rollover
                  if (leap_ff == LEAP_POS) limit = 8'd60;
                  else if (leap_ff == LEAP_NEG) limit = 8'd58;
                  s = sec_sh_ff + 8'd1;
                  m = min_sh_ff;
                  h = hour_sh_ff;
                  d = day_sh_ff;
                  y = year_sh_ff;
                  if (s > limit) begin
                     s = 8'd0;
                     m = m + 8'd1;
                     if (m > 8'd59) begin
                        m = 8'd0;
                        h = h + 8'd1;
                        if (h > 8'd23) begin
                           h = 8'd0;
                           d = d + 16'd1;
                           if (d > ((y[1:0] == 2'd0) ? 16'd366 : 16'd365)) begin
                              d = 16'd1;
                              y = y + 8'd1;
                              if (y > 8'd99) y = 8'd0;
                           end
                        end
                     end
                  end
                  p_sec_in  = s[5:0];
                  p_min_in  = m[5:0];
                  p_hour_in = h[4:0];
                  p_day_in  = d[8:0];
                  p_year_in = y[6:0];
                  p_mon_in  = 4'd0;
                  p_qual_in = qual_sh_ff[3:0];
                  p_ms_in   = 10'd0;
                  m_idx_in  = 4'd0;
                  m_sum_in  = 9'd0;
                  state_in  = BK_MONTH;
               end else begin
                  out_push = 1'b1;
                  out_word = '{in_frame: (pos_in != POS_UNALIGNED), frame_done: 1'b0,
                               out_year: p_year_ff, out_month: p_mon_ff,
                               out_day: p_day_ff, out_hour: p_hour_ff,
                               out_minute: p_min_ff, out_second: p_sec_ff,
                               out_millisecond: p_ms_in, out_quality: p_qual_in,
                               leap_flag: leap_in};
               end
            end
         end
         BK_MONTH: begin
            // walk one month a cycle
            lp  = (p_year_ff[1:0] == 2'd0);
            len = month_len(m_idx_ff, lp);
            if ({1'b0, p_day_ff} <= {1'b0, m_sum_ff} + {5'd0, len}) begin
               p_mon_in = m_idx_ff + 4'd1;
               p_day_in = p_day_ff - m_sum_ff;
               state_in = BK_DONE;
            end else begin
               m_sum_in = m_sum_ff + {4'd0, len};
               m_idx_in = m_idx_ff + 4'd1;
               if (m_idx_ff == 4'd11) state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            out_push = 1'b1;
            out_word = '{in_frame: 1'b1, frame_done: 1'b1,
                         out_year: p_year_ff, out_month: p_mon_ff,
                         out_day: p_day_ff, out_hour: p_hour_ff,
                         out_minute: p_min_ff, out_second: p_sec_ff,
                         out_millisecond: p_ms_ff, out_quality: p_qual_ff,
                         leap_flag: leap_ff};
            state_in = BK_RUN;
         end
         default: state_in = BK_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_RUN;
         pos_ff     <= POS_UNALIGNED;
         leap_ff    <= LEAP_NONE;
         sec_sh_ff  <= '0;
         min_sh_ff  <= '0;
         hour_sh_ff <= '0;
         day_sh_ff  <= '0;
         year_sh_ff <= '0;
         qual_sh_ff <= '0;
         p_year_ff  <= '0;
         p_mon_ff   <= '0;
         p_day_ff   <= '0;
         p_hour_ff  <= '0;
         p_min_ff   <= '0;
         p_sec_ff   <= '0;
         p_ms_ff    <= '0;
         p_qual_ff  <= QUAL_BAD;
         m_idx_ff   <= '0;
         m_sum_ff   <= '0;
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         count_ff   <= 2'd0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         leap_ff    <= leap_in;
         sec_sh_ff  <= sec_sh_in;
         min_sh_ff  <= min_sh_in;
         hour_sh_ff <= hour_sh_in;
         day_sh_ff  <= day_sh_in;
         year_sh_ff <= year_sh_in;
         qual_sh_ff <= qual_sh_in;
         p_year_ff  <= p_year_in;
         p_mon_ff   <= p_mon_in;
         p_day_ff   <= p_day_in;
         p_hour_ff  <= p_hour_in;
         p_min_ff   <= p_min_in;
         p_sec_ff   <= p_sec_in;
         p_ms_ff    <= p_ms_in;
         p_qual_ff  <= p_qual_in;
         m_idx_ff   <= m_idx_in;
         m_sum_ff   <= m_sum_in;
         if (out_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop && !empty) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, out_push} - {1'b0, pop && !empty};
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) q_ff[wr_ptr_ff] <= out_word;
   end

endmodule
`default_nettype wire

FILE: hdl/irig_b_time_code_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IRIG-B time code decoder
// Turns edge and timeout events into framed, published time words.
// ----------------------------------------------------------------------------
// Input side is a queue: drive req_word and push; the word is taken when full
// is low. Each word is a line edge (new level, ticks since last edge) or a
// bit timeout. Output side is a queue: while empty is low rsp_word holds the
// oldest result; pop takes it. Every input word yields exactly one result.
// The width registers are written through csr_wr_en/csr_index/csr_wdata.
// A word is registered in the classifier queue, then its result in the output
// queue. Throughput is one word per cycle while the output queue has room and
// no frame is being published, set by the framer's single decode step; the
// word that closes a frame is further held by the month walk (one month per
// cycle) and the publish step. A two-entry queue sits between classifier and
// framer and another on the output, so a stalled receiver first fills the
// output queue, then holds the framer, then the classifier raises full.
// Reset returns the widths to their defaults, the framer to unaligned and the
// published quality to bad; both queues are emptied.
// ----------------------------------------------------------------------------
module irig_b_time_code_decoder (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire irigb_pkg::req_type   req_word,
   output logic                      empty,
   input  wire logic                 pop,
   output irigb_pkg::rsp_type        rsp_word,
   input  wire logic                 csr_wr_en,
   input  wire logic [1:0]           csr_index,
   input  wire logic [17:0]          csr_wdata
);
   import irigb_pkg::*;

   sym_link_type sym_link;
   logic         sym_pop;

   irigb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sym_link  (sym_link),
      .sym_pop   (sym_pop)
   );

   irigb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .sym_link (sym_link),
      .sym_pop  (sym_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

endmodule
`default_nettype wire
